// ===== hdl/ptwc_pkg.sv =====
`timescale 1ns / 1ps

package ptwc_pkg;

    localparam int HALF_LENGTH_DEFAULT = 1024;

    localparam int SAMPLE_W = 12;
    localparam int OFFSET_W = 10;
    localparam int COUNT_W  = 11;
    localparam int SUM_W    = 23;
    localparam int DEBUG_W  = 8;
    localparam int DSEL_W   = 3;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'h100;
    localparam logic [DEBUG_W-1:0]  DEBUG_FILL   = 8'h55;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_M  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_X  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBUG_SELECT = 2'd2;

    // debug byte sources
    localparam logic [DSEL_W-1:0] DSEL_POSITION = 3'd0;
    localparam logic [DSEL_W-1:0] DSEL_BUFFERED = 3'd1;
    localparam logic [DSEL_W-1:0] DSEL_M        = 3'd2;
    localparam logic [DSEL_W-1:0] DSEL_X        = 3'd3;
    localparam logic [DSEL_W-1:0] DSEL_AUX      = 3'd4;
    localparam logic [DSEL_W-1:0] DSEL_RESET    = DSEL_M;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_aux;
        logic [SAMPLE_W-1:0] sample_x;
        logic [SAMPLE_W-1:0] sample_m;
        logic [SAMPLE_W-1:0] sample_buffered;
    } in_word_t;

    typedef struct packed {
        logic [1:0]          pad;
        logic [SUM_W-1:0]    sum_x_out;
        logic [COUNT_W-1:0]  count_x;
        logic [COUNT_W-1:0]  count_m;
        logic [DEBUG_W-1:0]  debug_byte;
        logic                ready_b;
        logic                ready_a;
        logic [SAMPLE_W-1:0] write_data;
        logic [OFFSET_W-1:0] write_offset;
        logic                write_bank;
    } out_word_t;

    typedef struct packed {
        logic      report_valid;
        out_word_t word;
    } result_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold_m;
        logic [SAMPLE_W-1:0] threshold_x;
        logic [DSEL_W-1:0]   debug_select;
    } cfg_t;

endpackage

// ===== hdl/ptwc_window.sv =====
`timescale 1ns / 1ps

module ptwc_window
    import ptwc_pkg::*;
#(
    parameter int HALF_LENGTH = HALF_LENGTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_word_t item,
    input  cfg_t     cfg,
    output result_t  result
);

    localparam int POS_W = $clog2(2 * HALF_LENGTH + 1);
    localparam logic [POS_W-1:0] HALF = POS_W'(HALF_LENGTH);
    localparam logic [POS_W-1:0] FULL = POS_W'(2 * HALF_LENGTH);
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    logic [POS_W-1:0]   position_reg;
    logic [POS_W-1:0]   position_next;
    logic [COUNT_W-1:0] run_count_m_reg;
    logic [COUNT_W-1:0] run_count_m_next;
    logic [COUNT_W-1:0] run_count_x_reg;
    logic [COUNT_W-1:0] run_count_x_next;
    logic [SUM_W-1:0]   run_sum_x_reg;
    logic [SUM_W-1:0]   run_sum_x_next;

    logic [COUNT_W-1:0] count_m_acc;
    logic [COUNT_W-1:0] count_x_acc;
    logic [SUM_W-1:0]   sum_x_acc;
    logic               hit_m;
    logic               hit_x;
    logic               boundary;
    logic [POS_W-1:0]   offset_full;
    logic [POS_W+OFFSET_W-1:0] offset_ext;
    logic [POS_W+DEBUG_W-1:0]  position_ext;
    logic [DEBUG_W-1:0] debug_byte;

    assign hit_m    = item.sample_m >= cfg.threshold_m;
    assign hit_x    = item.sample_x >= cfg.threshold_x;
    assign boundary = (position_reg == HALF) || (position_reg == FULL);

    assign count_m_acc = run_count_m_reg + COUNT_W'(hit_m);
    assign count_x_acc = run_count_x_reg + COUNT_W'(hit_x);
    assign sum_x_acc   = hit_x ? run_sum_x_reg + SUM_W'(item.sample_x) : run_sum_x_reg;

    assign offset_full  = (position_reg < HALF) ? position_reg :
                          (position_reg < FULL) ? position_reg - HALF : '0;
    assign offset_ext   = {{OFFSET_W{1'b0}}, offset_full};
    assign position_ext = {{DEBUG_W{1'b0}}, position_reg};

    always_comb
    begin
        case (cfg.debug_select)
            DSEL_POSITION: debug_byte = position_ext[DEBUG_W-1:0];
            DSEL_BUFFERED: debug_byte = item.sample_buffered[SAMPLE_W-1:4];
            DSEL_M:        debug_byte = item.sample_m[SAMPLE_W-1:4];
            DSEL_X:        debug_byte = item.sample_x[SAMPLE_W-1:4];
            DSEL_AUX:      debug_byte = item.sample_aux[SAMPLE_W-1:4];
            default:       debug_byte = DEBUG_FILL;
        endcase
    end

    always_comb
    begin
        result.report_valid      = boundary;
        result.word.pad          = '0;
        result.word.write_bank   = (position_reg >= HALF) && (position_reg < FULL);
        result.word.write_offset = offset_ext[OFFSET_W-1:0];
        result.word.write_data   = item.sample_buffered;
        result.word.ready_a      = position_reg == HALF;
        result.word.ready_b      = position_reg >= FULL;
        result.word.debug_byte   = debug_byte;
        result.word.count_m      = boundary ? count_m_acc : '0;
        result.word.count_x      = boundary ? count_x_acc : '0;
        result.word.sum_x_out    = boundary ? sum_x_acc : '0;
    end

    always_comb
    begin
        position_next    = position_reg;
        run_count_m_next = run_count_m_reg;
        run_count_x_next = run_count_x_reg;
        run_sum_x_next   = run_sum_x_reg;
        if (step)
        begin
            position_next    = (position_reg < FULL) ? position_reg + POS_ONE : POS_ONE;
            run_count_m_next = boundary ? '0 : count_m_acc;
            run_count_x_next = boundary ? '0 : count_x_acc;
            run_sum_x_next   = boundary ? '0 : sum_x_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            run_count_m_reg <= '0;
            run_count_x_reg <= '0;
            run_sum_x_reg   <= '0;
        end
        else
        begin
            position_reg    <= position_next;
            run_count_m_reg <= run_count_m_next;
            run_count_x_reg <= run_count_x_next;
            run_sum_x_reg   <= run_sum_x_next;
        end
    end

endmodule

// ===== hdl/pingpong_threshold_window_counter.sv =====
`timescale 1ns / 1ps
// an input word passes the input register and the result register to reach m_tdata
// one word per cycle while m_tready is high; input and result register stall together
// position, window counters and sum update as a word leaves the input register
// reset (rst_n low, asynchronous) clears position, counters, valids and sets
// thresholds to 0x100 and debug select to channel two

module pingpong_threshold_window_counter
    import ptwc_pkg::*;
#(
    parameter int HALF_LENGTH = HALF_LENGTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sample_buffered, sample_m, sample_x, sample_aux
    input  logic [S_TDATA_W-1:0]   s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // write_bank, write_offset, write_data, ready_a, ready_b, debug_byte,
    // count_m, count_x, sum_x_out, zero pad
    output logic [M_TDATA_W-1:0]   m_tdata,
    // report_valid
    output logic                   m_tuser,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]    cfg_data
);

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic      out_user_reg;
    logic      advance;
    logic      step;
    result_t   result;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = advance && in_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_m  <= THRESH_RESET;
            cfg_reg.threshold_x  <= THRESH_RESET;
            cfg_reg.debug_select <= DSEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD_M:  cfg_reg.threshold_m  <= cfg_data;
                CFG_THRESHOLD_X:  cfg_reg.threshold_x  <= cfg_data;
                CFG_DEBUG_SELECT: cfg_reg.debug_select <= cfg_data[DSEL_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg <= s_tdata;
        end
        if (step)
        begin
            out_word_reg <= result.word;
            out_user_reg <= result.report_valid;
        end
    end

    ptwc_window #(
        .HALF_LENGTH (HALF_LENGTH)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_word_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule

// ===== hdl/ptwc_checker.sv =====
`timescale 1ns / 1ps

module ptwc_checker
    import ptwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser
);

    out_word_t word;

    assign word = m_tdata;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a report goes out exactly with a bank-full pulse, never both pulses at once
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (word.ready_a || word.ready_b))
                     && !(word.ready_a && word.ready_b))
        else $error("report flag and bank pulses disagree");

    // counters read zero outside a report
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> word.count_m == '0 && word.count_x == '0
                                 && word.sum_x_out == '0)
        else $error("nonzero counters without report");

    // bank a full means the write moves to the start of bank b
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && word.ready_a |-> word.write_bank && word.write_offset == '0)
        else $error("bank a pulse with wrong write address");

    // bank b full means the write wraps to the start of bank a
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && word.ready_b |-> !word.write_bank && word.write_offset == '0)
        else $error("bank b pulse with wrong write address");

endmodule

bind pingpong_threshold_window_counter ptwc_checker u_ptwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/pingpong_threshold_window_counter_tb.sv =====
`timescale 1ns / 1ps

module pingpong_threshold_window_counter_tb;
    import ptwc_pkg::*;

    localparam int HALF = HALF_LENGTH_DEFAULT;
    localparam int FULL = 2 * HALF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SET_TARGET = 1700;
    localparam int MAX_REPORTS = 40;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // sample_buffered, sample_m, sample_x, sample_aux
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // write_bank, write_offset, write_data, ready_a, ready_b, debug_byte,
    // count_m, count_x, sum_x_out, zero pad
    logic [M_TDATA_W-1:0]   m_tdata;
    // report_valid
    logic                   m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]    cfg_data = '0;

    // predictor state and register mirror
    int                  position = 0;
    int                  run_m = 0;
    int                  run_x = 0;
    int                  run_sum = 0;
    logic [SAMPLE_W-1:0] thr_m = THRESH_RESET;
    logic [SAMPLE_W-1:0] thr_x = THRESH_RESET;
    logic [DSEL_W-1:0]   dsel = DSEL_RESET;

    in_word_t  sample_sets[$];
    result_t   buffer_writes_due[$];
    in_word_t  sent_word;
    result_t   due_result;
    out_word_t seen_word;

    int sets_queued = 0;
    int results_checked = 0;
    int mismatches = 0;
    int cycles = 0;
    int idle_on = 0;
    int send_gap = 0;
    int stall_left = 0;

    pingpong_threshold_window_counter #(
        .HALF_LENGTH (HALF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic result_t advance_window(in_word_t w);
        result_t r;
        int      p;
        logic    boundary;
        p = position;
        boundary = (p == HALF) || (p == FULL);
        r = '0;
        if (p < HALF)
        begin
            r.word.write_bank = 1'b0;
            r.word.write_offset = OFFSET_W'(p);
        end
        else if (p == HALF)
        begin
            r.word.write_bank = 1'b1;
            r.word.ready_a = 1'b1;
        end
        else if (p < FULL)
        begin
            r.word.write_bank = 1'b1;
            r.word.write_offset = OFFSET_W'(p - HALF);
        end
        else
        begin
            r.word.write_bank = 1'b0;
            r.word.ready_b = 1'b1;
        end
        r.word.write_data = w.sample_buffered;
        if (w.sample_m >= thr_m)
            run_m++;
        if (w.sample_x >= thr_x)
        begin
            run_x++;
            run_sum += int'(w.sample_x);
        end
        if (boundary)
        begin
            r.report_valid = 1'b1;
            r.word.count_m = COUNT_W'(run_m);
            r.word.count_x = COUNT_W'(run_x);
            r.word.sum_x_out = SUM_W'(run_sum);
            run_m = 0;
            run_x = 0;
            run_sum = 0;
        end
        case (dsel)
            DSEL_POSITION: r.word.debug_byte = DEBUG_W'(p);
            DSEL_BUFFERED: r.word.debug_byte = w.sample_buffered[SAMPLE_W-1:4];
            DSEL_M:        r.word.debug_byte = w.sample_m[SAMPLE_W-1:4];
            DSEL_X:        r.word.debug_byte = w.sample_x[SAMPLE_W-1:4];
            DSEL_AUX:      r.word.debug_byte = w.sample_aux[SAMPLE_W-1:4];
            default:       r.word.debug_byte = DEBUG_FILL;
        endcase
        position = (p < FULL) ? p + 1 : 1;
        return r;
    endfunction

    // mostly short pauses, a few long ones
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (idle_on == 0 || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] level);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return SAMPLE_MAX;
        else if (r < 40)
        begin
            v = int'(level) + $urandom_range(0, 2) - 1;
            if (v < 0)
                v = 0;
            if (v > int'(SAMPLE_MAX))
                v = int'(SAMPLE_MAX);
            return SAMPLE_W'(v);
        end
        else
            return SAMPLE_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return SAMPLE_MAX;
        else if (r < 4)
            return SAMPLE_W'($urandom_range(200, 320));
        else
            return SAMPLE_W'($urandom_range(0, 4095));
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_set(input logic [SAMPLE_W-1:0] b, input logic [SAMPLE_W-1:0] m,
                             input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] a);
        in_word_t w;
        w.sample_buffered = b;
        w.sample_m = m;
        w.sample_x = x;
        w.sample_aux = a;
        sample_sets.push_back(w);
        sets_queued++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD_M:  thr_m = value;
            CFG_THRESHOLD_X:  thr_x = value;
            CFG_DEBUG_SELECT: dsel = value[DSEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (results_checked != sets_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // sample set driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                sent_word = in_word_t'(s_tdata);
                buffer_writes_due.push_back(advance_window(sent_word));
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (sample_sets.size() != 0)
                begin
                    s_tdata <= sample_sets.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= pause_length();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result word monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_word = out_word_t'(m_tdata);
                if (buffer_writes_due.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t unexpected word expected none actual %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    due_result = buffer_writes_due.pop_front();
                    check_field("write_bank", due_result.word.write_bank, seen_word.write_bank);
                    check_field("write_offset", due_result.word.write_offset,
                                seen_word.write_offset);
                    check_field("write_data", due_result.word.write_data, seen_word.write_data);
                    check_field("ready_a", due_result.word.ready_a, seen_word.ready_a);
                    check_field("ready_b", due_result.word.ready_b, seen_word.ready_b);
                    check_field("debug_byte", due_result.word.debug_byte, seen_word.debug_byte);
                    check_field("report_valid", due_result.report_valid, m_tuser);
                    check_field("count_m", due_result.word.count_m, seen_word.count_m);
                    check_field("count_x", due_result.word.count_x, seen_word.count_x);
                    check_field("sum_x_out", due_result.word.sum_x_out, seen_word.sum_x_out);
                    results_checked++;
                end
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left <= pause_length();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int sel;
        int len;
        int k;
        logic [SAMPLE_W-1:0] level_m;
        logic [SAMPLE_W-1:0] level_x;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, levels just at and below the default thresholds
        idle_on = 1;
        queue_set('0, '0, '0, '0);
        queue_set(SAMPLE_MAX, THRESH_RESET, THRESH_RESET - 1, SAMPLE_MAX);
        queue_set(12'h5A5, THRESH_RESET - 1, THRESH_RESET, 12'hA5A);

        // every debug source, threshold extremes
        for (sel = 0; sel < 8; sel++)
        begin
            wait_idle();
            if (sel == 0)
                write_reg(CFG_UNUSED, SAMPLE_MAX);
            level_m = (sel & 1) ? SAMPLE_W'(4095 - (sel >> 1) * 1024)
                                : SAMPLE_W'((sel >> 1) * 1024);
            level_x = ((7 - sel) & 1) ? SAMPLE_W'(4095 - ((7 - sel) >> 1) * 1024)
                                      : SAMPLE_W'(((7 - sel) >> 1) * 1024);
            write_reg(CFG_DEBUG_SELECT, SAMPLE_W'(sel));
            write_reg(CFG_THRESHOLD_M, level_m);
            write_reg(CFG_THRESHOLD_X, level_x);
            queue_set('0, '0, '0, '0);
            queue_set(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
            queue_set(SAMPLE_W'($urandom_range(0, 4095)), level_m, level_x,
                      SAMPLE_W'($urandom_range(0, 4095)));
        end

        // random phases, together long enough to pass the first window boundary
        while (sets_queued < SET_TARGET)
        begin
            wait_idle();
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_UNUSED, SAMPLE_W'($urandom_range(0, 4095)));
            write_reg(CFG_THRESHOLD_M, pick_threshold());
            write_reg(CFG_THRESHOLD_X, pick_threshold());
            write_reg(CFG_DEBUG_SELECT, {SAMPLE_W'($urandom_range(0, 511)) << DSEL_W}
                                        | SAMPLE_W'($urandom_range(0, 7)));
            idle_on = ($urandom_range(0, 3) != 0) ? 1 : 0;
            len = $urandom_range(100, 400);
            for (k = 0; k < len; k++)
                queue_set(pick_sample(SAMPLE_W'($urandom_range(0, 4095))), pick_sample(thr_m),
                          pick_sample(thr_x), pick_sample(SAMPLE_W'($urandom_range(0, 4095))));
        end

        wait_idle();
        if (buffer_writes_due.size() != 0)
        begin
            $display("%0t leftover words expected 0 actual %0d", $time,
                     buffer_writes_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ptwc_pkg.sv
hdl/ptwc_window.sv
hdl/pingpong_threshold_window_counter.sv
hdl/ptwc_checker.sv
tb/sv/pingpong_threshold_window_counter_tb.sv
